FILE: rtl/srlm_pkg.sv
// Shared constants, types and codes for the stereo RMS level meter.
package srlm_pkg;

	localparam int MAX_BLOCK_FRAMES_DEF = 4096;
	localparam int SAMPLE_BITS_DEF      = 16;

	localparam int OUT_W       = 15;
	localparam int OUT_TDATA_W = 48;
	localparam int KEEP_W      = 16;
	localparam int BF_W        = 13;
	localparam int FS_W        = 15;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int SMOOTH_W    = 16;

	localparam logic [BF_W-1:0]   BLOCK_FRAMES_RST   = 13'd512;
	localparam logic [KEEP_W-1:0] SMOOTH_KEEP_RST    = 16'd60948;
	localparam logic [FS_W-1:0]   MAP_FULL_SCALE_RST = 15'd5571;

	localparam logic [OUT_W-1:0]    VOL_LOW    = 15'd4096;
	localparam logic [OUT_W-1:0]    VOL_SPAN   = 15'd14336;
	localparam logic [OUT_W-1:0]    VOL_HIGH   = 15'd18432;
	localparam logic [OUT_W-1:0]    RMS_MAX    = 15'd16384;
	localparam logic [SMOOTH_W-1:0] SMOOTH_MAX = 16'd32768;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_FRAMES   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_KEEP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_FULL_SCALE = 2'd2;

	typedef enum logic [14:0] {
		ST_IDLE      = 15'h0001,
		ST_SQ_LEFT   = 15'h0002,
		ST_SQ_RIGHT  = 15'h0004,
		ST_ACC       = 15'h0008,
		ST_MEAN_GO   = 15'h0010,
		ST_MEAN_WAIT = 15'h0020,
		ST_ROOT_INIT = 15'h0040,
		ST_ROOT      = 15'h0080,
		ST_SM_A      = 15'h0100,
		ST_SM_B      = 15'h0200,
		ST_SM_C      = 15'h0400,
		ST_VOL_A     = 15'h0800,
		ST_VOL_GO    = 15'h1000,
		ST_VOL_WAIT  = 15'h2000,
		ST_FINISH    = 15'h4000
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic load_in;
		logic sq_left;
		logic sq_right;
		logic acc;
		logic mean_go;
		logic root_init;
		logic root_step;
		logic sm_a;
		logic sm_b;
		logic sm_c;
		logic vol_a;
		logic vol_go;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic div_done;
		logic root_last;
	} sts_t;

endpackage

FILE: rtl/srlm_div.sv
// Restoring divider, one quotient bit per cycle.
module srlm_div #(
	parameter int NUM_W = 44,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic             done
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] q_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, q_q[NUM_W-1]};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			q_q   <= {q_q[NUM_W-2:0], ge};
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		end
	end

	assign quo  = q_q;
	assign done = done_q;

endmodule

FILE: rtl/srlm_dp.sv
// Datapath: squaring and accumulation, mean divide, square root, smoothing, volume map.
module srlm_dp #(
	parameter int MAX_BLOCK_FRAMES = srlm_pkg::MAX_BLOCK_FRAMES_DEF,
	parameter int SAMPLE_BITS      = srlm_pkg::SAMPLE_BITS_DEF,
	parameter int LEN_W            = $clog2(MAX_BLOCK_FRAMES + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  srlm_pkg::cmd_t                  cmd,
	output srlm_pkg::sts_t                  sts,
	input  logic signed [SAMPLE_BITS-1:0]   left_sample,
	input  logic signed [SAMPLE_BITS-1:0]   right_sample,
	input  logic [LEN_W-1:0]                block_len,
	input  logic [srlm_pkg::KEEP_W-1:0]     smooth_keep,
	input  logic [srlm_pkg::FS_W-1:0]       full_scale,
	output logic [srlm_pkg::OUT_W-1:0]      rms_level,
	output logic [srlm_pkg::OUT_W-1:0]      smoothed_level,
	output logic [srlm_pkg::OUT_W-1:0]      scaled_volume
);
	import srlm_pkg::*;

	localparam int SUM_W = 2 * SAMPLE_BITS + $clog2(MAX_BLOCK_FRAMES);
	localparam int DEN_W = (LEN_W + 3 > 16) ? LEN_W + 3 : 16;
	localparam int NUM_W = (SUM_W > 30) ? SUM_W : 30;
	localparam int SQ_W  = NUM_W + (NUM_W % 2);
	localparam int ROOT_W = SQ_W / 2;
	localparam int SQC_W = $clog2(ROOT_W);
	localparam int MOP_W = (SAMPLE_BITS > 17) ? SAMPLE_BITS : 17;
	localparam int PROD_W = 2 * MOP_W;
	localparam int ACC_W = 34;
	localparam int LSH = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
	localparam int RSH = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 0;

	logic [SAMPLE_BITS-1:0] mag_l_q, mag_r_q;
	logic [MOP_W-1:0]       op_a, op_b;
	logic [PROD_W-1:0]      prod_q;
	logic [SUM_W-1:0]       sum_q;
	logic [LEN_W-1:0]       count_q;
	logic [ACC_W-1:0]       acc_q;
	logic [SMOOTH_W-1:0]    smoothed_q;
	logic [OUT_W-1:0]       rms_q;

	logic [SQ_W-1:0]        sq_x_q;
	logic [ROOT_W:0]        sq_rem_q;
	logic [ROOT_W-1:0]      sq_root_q;
	logic [SQC_W-1:0]       sq_cnt_q;
	logic [ROOT_W+2:0]      sq_r, sq_t;
	logic                   sq_ge;

	logic                   div_start;
	logic [NUM_W-1:0]       div_num, div_quo;
	logic [DEN_W-1:0]       div_den;
	logic                   div_done;

	logic [ROOT_W+15:0]     root_ext;
	logic [OUT_W-1:0]       rms_c;
	logic [ACC_W-1:0]       sm_sum;
	logic [ACC_W-17:0]      sm_shift;
	logic [KEEP_W:0]        keep_cpl;

	// two's-complement magnitude; the most negative code yields 2^(SAMPLE_BITS-1)
	function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] s);
		return s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
	endfunction

	assign keep_cpl = (KEEP_W + 1)'(1 << KEEP_W) - {1'b0, smooth_keep};

	always_comb begin
		op_a = MOP_W'(mag_l_q);
		op_b = MOP_W'(mag_l_q);
		if (cmd.sq_right) begin
			op_a = MOP_W'(mag_r_q);
			op_b = MOP_W'(mag_r_q);
		end else if (cmd.sm_a) begin
			op_a = MOP_W'(smooth_keep);
			op_b = MOP_W'(smoothed_q);
		end else if (cmd.sm_b) begin
			op_a = MOP_W'(keep_cpl);
			op_b = MOP_W'({rms_q, 1'b0});
		end else if (cmd.vol_a) begin
			op_a = MOP_W'(smoothed_q);
			op_b = MOP_W'(VOL_SPAN);
		end
	end

	// isqrt step: two radicand bits per cycle
	assign sq_r  = {sq_rem_q, sq_x_q[SQ_W-1 -: 2]};
	assign sq_t  = {1'b0, sq_root_q, 2'b01};
	assign sq_ge = (sq_r >= sq_t);

	assign root_ext = ((ROOT_W + 16)'(sq_root_q) << LSH) >> RSH;
	assign rms_c    = (root_ext > (ROOT_W + 16)'(RMS_MAX)) ? RMS_MAX : root_ext[OUT_W-1:0];

	assign sm_sum   = acc_q + ACC_W'(prod_q);
	assign sm_shift = sm_sum[ACC_W-1:16];

	assign div_start = cmd.mean_go | cmd.vol_go;
	assign div_num   = cmd.vol_go ? NUM_W'(prod_q) : NUM_W'(sum_q);
	assign div_den   = cmd.vol_go ? DEN_W'({full_scale, 1'b0}) : DEN_W'({count_q, 3'b000});

	srlm_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.done   (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			count_q    <= '0;
			smoothed_q <= '0;
		end else begin
			if (cmd.sq_right || cmd.acc)
				sum_q <= sum_q + SUM_W'(prod_q);
			if (cmd.acc)
				count_q <= count_q + 1'b1;
			if (cmd.finish) begin
				sum_q   <= '0;
				count_q <= '0;
			end
			if (cmd.sm_c)
				smoothed_q <= (sm_shift > (ACC_W - 16)'(SMOOTH_MAX)) ? SMOOTH_MAX
					: sm_shift[SMOOTH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mag_l_q <= magnitude(left_sample);
			mag_r_q <= magnitude(right_sample);
		end
		if (cmd.sq_left || cmd.sq_right || cmd.sm_a || cmd.sm_b || cmd.vol_a)
			prod_q <= op_a * op_b;
		if (cmd.sm_a)
			rms_q <= rms_c;
		if (cmd.sm_b)
			acc_q <= ACC_W'(prod_q);
		if (cmd.root_init) begin
			sq_x_q    <= SQ_W'(div_quo);
			sq_rem_q  <= '0;
			sq_root_q <= '0;
			sq_cnt_q  <= '0;
		end else if (cmd.root_step) begin
			sq_x_q    <= {sq_x_q[SQ_W-3:0], 2'b00};
			sq_rem_q  <= sq_ge ? (ROOT_W + 1)'(sq_r - sq_t) : sq_r[ROOT_W:0];
			sq_root_q <= {sq_root_q[ROOT_W-2:0], sq_ge};
			sq_cnt_q  <= sq_cnt_q + 1'b1;
		end
	end

	assign sts.last      = (LEN_W + 1)'(count_q) + 1'b1 >= (LEN_W + 1)'(block_len);
	assign sts.div_done  = div_done;
	assign sts.root_last = (sq_cnt_q == SQC_W'(ROOT_W - 1));

	assign rms_level      = rms_q;
	assign smoothed_level = smoothed_q[SMOOTH_W-1:1];
	assign scaled_volume  = VOL_LOW + ((div_quo > NUM_W'(VOL_SPAN)) ? VOL_SPAN : div_quo[OUT_W-1:0]);

endmodule

FILE: rtl/srlm_ctrl.sv
// Controller state machine sequencing the datapath per frame and per block.
module srlm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           out_free,
	input  srlm_pkg::sts_t sts,
	output srlm_pkg::cmd_t cmd
);
	import srlm_pkg::*;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_SQ_LEFT;
				end
			end
			ST_SQ_LEFT: begin
				cmd.sq_left = 1'b1;
				state_d     = ST_SQ_RIGHT;
			end
			ST_SQ_RIGHT: begin
				cmd.sq_right = 1'b1;
				state_d      = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.last ? ST_MEAN_GO : ST_IDLE;
			end
			ST_MEAN_GO: begin
				cmd.mean_go = 1'b1;
				state_d     = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: begin
				if (sts.div_done)
					state_d = ST_ROOT_INIT;
			end
			ST_ROOT_INIT: begin
				cmd.root_init = 1'b1;
				state_d       = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (sts.root_last)
					state_d = ST_SM_A;
			end
			ST_SM_A: begin
				cmd.sm_a = 1'b1;
				state_d  = ST_SM_B;
			end
			ST_SM_B: begin
				cmd.sm_b = 1'b1;
				state_d  = ST_SM_C;
			end
			ST_SM_C: begin
				cmd.sm_c = 1'b1;
				state_d  = ST_VOL_A;
			end
			ST_VOL_A: begin
				cmd.vol_a = 1'b1;
				state_d   = ST_VOL_GO;
			end
			ST_VOL_GO: begin
				cmd.vol_go = 1'b1;
				state_d    = ST_VOL_WAIT;
			end
			ST_VOL_WAIT: begin
				if (sts.div_done)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				// hold until the output register can take the word
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

FILE: rtl/stereo_rms_level_meter_top.sv
// Top level: stream ports, configuration registers, output register.
// Inside a block a new stereo frame is taken only after the previous one is squared and accumulated.
// After a block-ending frame, the next frame is not taken until the serial divider (mean, volume
// map), the two-bit-per-cycle root and smoothing are done; longer while the prior word is unread.
// Reset (arst_n low) clears state, counters, the smoothed level and loads register defaults.
module stereo_rms_level_meter_top #(
	parameter int MAX_BLOCK_FRAMES = srlm_pkg::MAX_BLOCK_FRAMES_DEF,
	parameter int SAMPLE_BITS      = srlm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [SAMPLE_BITS-1:0] left_sample, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_sample, zero pad
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [14:0] rms_level, [29:15] smoothed_level, [44:30] scaled_volume, [47:45] zero
	output logic [srlm_pkg::OUT_TDATA_W-1:0]      m_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [srlm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [srlm_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import srlm_pkg::*;

	localparam int LEN_W = $clog2(MAX_BLOCK_FRAMES + 1);

	logic [BF_W-1:0]        block_frames_q;
	logic [KEEP_W-1:0]      smooth_keep_q;
	logic [FS_W-1:0]        map_full_scale_q;
	logic [LEN_W-1:0]       block_len;
	logic [FS_W-1:0]        full_scale;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                   out_free;
	logic [OUT_W-1:0]       rms_level, smoothed_level, scaled_volume;
	cmd_t                   cmd;
	sts_t                   sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_frames_q   <= BLOCK_FRAMES_RST;
			smooth_keep_q    <= SMOOTH_KEEP_RST;
			map_full_scale_q <= MAP_FULL_SCALE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BLOCK_FRAMES:   block_frames_q   <= cfg_data[BF_W-1:0];
				CFG_SMOOTH_KEEP:    smooth_keep_q    <= cfg_data[KEEP_W-1:0];
				CFG_MAP_FULL_SCALE: map_full_scale_q <= cfg_data[FS_W-1:0];
				default: ;
			endcase
		end
	end

	// zero block length counts as one; oversize saturates
	always_comb begin
		if (block_frames_q == '0)
			block_len = LEN_W'(1);
		else if (32'(block_frames_q) > 32'(MAX_BLOCK_FRAMES))
			block_len = LEN_W'(MAX_BLOCK_FRAMES);
		else
			block_len = LEN_W'(block_frames_q);
	end

	assign full_scale = (map_full_scale_q == '0) ? FS_W'(1) : map_full_scale_q;

	srlm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd)
	);

	srlm_dp #(
		.MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES),
		.SAMPLE_BITS      (SAMPLE_BITS),
		.LEN_W            (LEN_W)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.left_sample    ($signed(s_tdata[SAMPLE_BITS-1:0])),
		.right_sample   ($signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
		.block_len      (block_len),
		.smooth_keep    (smooth_keep_q),
		.full_scale     (full_scale),
		.rms_level      (rms_level),
		.smoothed_level (smoothed_level),
		.scaled_volume  (scaled_volume)
	);

	assign s_tready = cmd.in_ready;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (cmd.finish)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish)
			m_tdata_q <= OUT_TDATA_W'({scaled_volume, smoothed_level, rms_level});
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: rtl/srlm_checker.sv
// Port-level checker for the level meter, bound to the top level.
module srlm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [srlm_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import srlm_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// one frame at a time: ready drops after each accepted frame
	a_in_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("frame accepted on back-to-back cycles");

	a_vol_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[44:30] >= VOL_LOW && m_tdata[44:30] <= VOL_HIGH)
		else $error("scaled volume out of range");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[14:0] <= RMS_MAX && m_tdata[29:15] <= RMS_MAX
			&& m_tdata[47:45] == 3'b000)
		else $error("level out of range or pad bits set");

endmodule

bind stereo_rms_level_meter_top srlm_checker u_srlm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: test/level_meter_checker.sv
`timescale 1ns / 100ps
// Level meter checker: watches the three channels, predicts each block result and compares.
module level_meter_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	// [15:0] left_sample, [31:16] right_sample
	input  logic [31:0]                        s_tdata,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	// [14:0] rms_level, [29:15] smoothed_level, [44:30] scaled_volume, [47:45] zero
	input  logic [srlm_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [srlm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [srlm_pkg::CFG_DATA_W-1:0]    cfg_data,
	output int                                 fail_count,
	output int                                 outstanding
);
	import srlm_pkg::*;

	typedef struct packed {
		logic [OUT_W-1:0] volume;
		logic [OUT_W-1:0] smoothed;
		logic [OUT_W-1:0] rms;
	} level_word_t;

	logic [BF_W-1:0]   block_frames_reg;
	logic [KEEP_W-1:0] keep_reg;
	logic [FS_W-1:0]   full_scale_reg;

	int unsigned     frames_in_block;
	longint unsigned square_acc;
	longint unsigned smoothed_q16;
	level_word_t     level_q[$];

	int mismatches;

	level_word_t     want;
	level_word_t     got;
	longint unsigned mean_sq;
	longint unsigned root;
	longint unsigned mix;
	longint unsigned scale;
	longint unsigned vol;

	function automatic longint unsigned int_root(longint unsigned x);
		longint unsigned res;
		longint unsigned probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > x)
			probe = probe >> 2;
		while (probe != 0) begin
			if (x >= res + probe) begin
				x = x - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned square_of(logic signed [15:0] s);
		longint v;
		v = s;
		return v * v;
	endfunction

	// zero frames counts as one, oversize saturates
	function automatic int unsigned frames_per_block(logic [BF_W-1:0] n);
		if (n == 0)
			return 1;
		if (n > MAX_BLOCK_FRAMES_DEF)
			return MAX_BLOCK_FRAMES_DEF;
		return n;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_frames_reg = BLOCK_FRAMES_RST;
			keep_reg = SMOOTH_KEEP_RST;
			full_scale_reg = MAP_FULL_SCALE_RST;
			frames_in_block = 0;
			square_acc = 0;
			smoothed_q16 = 0;
			level_q.delete();
			mismatches = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[3*OUT_W-1:0];
				if (level_q.size() == 0) begin
					$error("result word with no expectation pending: %h", m_tdata);
					mismatches++;
				end else begin
					want = level_q.pop_front();
					if (got.rms !== want.rms) begin
						$error("rms_level: expected %0d, got %0d", want.rms, got.rms);
						mismatches++;
					end
					if (got.smoothed !== want.smoothed) begin
						$error("smoothed_level: expected %0d, got %0d",
							want.smoothed, got.smoothed);
						mismatches++;
					end
					if (got.volume !== want.volume) begin
						$error("scaled_volume: expected %0d, got %0d",
							want.volume, got.volume);
						mismatches++;
					end
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_BLOCK_FRAMES:   block_frames_reg = cfg_data[BF_W-1:0];
					CFG_SMOOTH_KEEP:    keep_reg = cfg_data[KEEP_W-1:0];
					CFG_MAP_FULL_SCALE: full_scale_reg = cfg_data[FS_W-1:0];
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				square_acc += square_of(s_tdata[15:0]) + square_of(s_tdata[31:16]);
				frames_in_block++;
				// lowering the block length mid block ends it on the next frame
				if (frames_in_block >= frames_per_block(block_frames_reg)) begin
					mean_sq = square_acc / (64'd8 * frames_in_block);
					root = int_root(mean_sq);
					if (root > RMS_MAX)
						root = RMS_MAX;
					mix = keep_reg * smoothed_q16 + (64'd65536 - keep_reg) * (root << 1);
					smoothed_q16 = mix >> 16;
					if (smoothed_q16 > SMOOTH_MAX)
						smoothed_q16 = SMOOTH_MAX;
					scale = (full_scale_reg == 0) ? 64'd1 : 64'(full_scale_reg);
					vol = VOL_LOW + (smoothed_q16 * VOL_SPAN) / (64'd2 * scale);
					if (vol > VOL_HIGH)
						vol = VOL_HIGH;
					want.rms = root[OUT_W-1:0];
					want.smoothed = smoothed_q16[OUT_W:1];
					want.volume = vol[OUT_W-1:0];
					level_q = {level_q, want};
					frames_in_block = 0;
					square_acc = 0;
				end
			end

			fail_count <= mismatches;
			outstanding <= level_q.size();
		end
	end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Level meter testbench top: clock, reset, stream and register stimulus, verdict.
module testbench;
	import srlm_pkg::*;

	localparam int PERIOD         = 8;
	localparam int SETTLE         = 250;
	localparam int HOLD_CYCLES    = 600;
	localparam int WATCHDOG_LIMIT = 8000;
	localparam int RANDOM_FRAMES  = 1700;
	localparam int PRESSURE_PHASE = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [31:0]            s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int   fail_count;
	int   outstanding;
	int   idle_cycles = 0;
	int   frames_sent = 0;
	logic gaps_off = 1'b0;
	logic hold_req = 1'b0;

	stereo_rms_level_meter_top dut (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	level_meter_checker meter_check (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.fail_count, .outstanding
	);

	always #(PERIOD/2) clk = ~clk;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side: random hold-off per word, one long hold on request
	initial begin : result_sink
		int wait_cycles;
		forever begin
			if (hold_req) begin
				wait_cycles = HOLD_CYCLES;
				hold_req = 1'b0;
			end else if (gaps_off) begin
				wait_cycles = 0;
			end else begin
				wait_cycles = $urandom_range(13, 0);
			end
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_frame(input logic [15:0] left, input logic [15:0] right);
		int gap;
		gap = gaps_off ? 0 : $urandom_range(13, 0);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {right, left};
		do @(posedge clk); while (!s_tready);
		frames_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_meter(input logic [15:0] frames, input logic [15:0] keep,
			input logic [15:0] full_scale, input logic stray);
		if (stray)
			write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
		write_reg(CFG_BLOCK_FRAMES, frames);
		write_reg(CFG_SMOOTH_KEEP, keep);
		write_reg(CFG_MAP_FULL_SCALE, full_scale);
		cfg_valid <= 1'b0;
	endtask

	// wait for every pending word, then for the tail of a block still in flight
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_sample(int shift);
		logic signed [15:0] v;
		v = 16'($urandom);
		case ($urandom_range(9, 0))
			0: begin
				case ($urandom_range(3, 0))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					default: return 16'hFFFF;
				endcase
			end
			1: return v;
			default: return v >>> shift;
		endcase
	endfunction

	initial begin
		logic [15:0] frames_word;
		logic [15:0] keep_word;
		logic [15:0] scale_word;
		int n;
		int amp;
		int phase;
		int base;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default registers, then block length lowered below the frames already in
		send_frame(16'h7FFF, 16'h8000);
		send_frame(16'h1234, 16'hFEDC);
		send_frame(16'h0000, 16'h0001);
		drain();
		program_meter(16'd2, SMOOTH_KEEP_RST, 16'(MAP_FULL_SCALE_RST), 1'b0);
		send_frame(16'h4000, 16'hC000);

		// single-frame blocks, no smoothing: rms and smoothed clamps
		drain();
		program_meter(16'd1, 16'd0, 16'd32767, 1'b1);
		send_frame(16'h8000, 16'h8000);
		send_frame(16'h7FFF, 16'h8000);
		send_frame(16'h0000, 16'h0000);
		send_frame(16'h0001, 16'hFFFF);

		// keep almost all, zero full scale
		drain();
		program_meter(16'd1, 16'hFFFF, 16'h0000, 1'b0);
		send_frame(16'h7FFF, 16'h7FFF);
		send_frame(16'h0000, 16'h0000);

		// zero block length, upper data bits set
		drain();
		program_meter(16'hE000, 16'd30000, 16'd1, 1'b0);
		send_frame(16'h8000, 16'h7FFF);
		send_frame(16'h3039, 16'hFFFF);

		// oversize block length, then lowered mid block
		drain();
		program_meter(16'd8191, SMOOTH_KEEP_RST, 16'(MAP_FULL_SCALE_RST), 1'b0);
		repeat (5) send_frame(pick_sample(4), pick_sample(4));
		drain();
		program_meter(16'd3, SMOOTH_KEEP_RST, 16'(MAP_FULL_SCALE_RST), 1'b0);
		send_frame(pick_sample(2), pick_sample(2));

		drain();
		program_meter(16'(MAX_BLOCK_FRAMES_DEF), SMOOTH_KEEP_RST, 16'(MAP_FULL_SCALE_RST),
			1'b0);
		repeat (3) send_frame(pick_sample(3), pick_sample(3));
		drain();
		program_meter(16'd2, SMOOTH_KEEP_RST, 16'h7FFF, 1'b0);
		send_frame(pick_sample(1), pick_sample(1));

		base = frames_sent;
		phase = 0;
		while ((frames_sent - base) < RANDOM_FRAMES) begin
			drain();
			case ($urandom_range(19, 0))
				0: frames_word = 16'd0;
				1: frames_word = 16'($urandom_range(8191, 13));
				2: frames_word = 16'(MAX_BLOCK_FRAMES_DEF);
				default: frames_word = 16'($urandom_range(12, 1));
			endcase
			frames_word[15:13] = 3'($urandom_range(7, 0));
			case ($urandom_range(5, 0))
				0: keep_word = 16'd0;
				1: keep_word = 16'hFFFF;
				2: keep_word = SMOOTH_KEEP_RST;
				default: keep_word = 16'($urandom);
			endcase
			case ($urandom_range(5, 0))
				0: scale_word = 16'd0;
				1: scale_word = 16'd1;
				2: scale_word = 16'd32767;
				3: scale_word = 16'($urandom);
				default: scale_word = 16'($urandom_range(8000, 500));
			endcase
			scale_word[15] = 1'($urandom_range(1, 0));
			gaps_off = ($urandom_range(4, 0) == 0);
			// long stall on the result side while frames keep coming
			if (phase == PRESSURE_PHASE) begin
				frames_word = 16'd2;
				gaps_off = 1'b1;
				hold_req = 1'b1;
			end
			program_meter(frames_word, keep_word, scale_word, $urandom_range(3, 0) == 0);
			amp = $urandom_range(15, 0);
			n = $urandom_range(150, 60);
			repeat (n) send_frame(pick_sample(amp), pick_sample(amp));
			phase++;
		end

		drain();
		if (fail_count == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/srlm_pkg.sv
rtl/srlm_div.sv
rtl/srlm_dp.sv
rtl/srlm_ctrl.sv
rtl/stereo_rms_level_meter_top.sv
rtl/srlm_checker.sv
test/level_meter_checker.sv
test/testbench.sv
